FILE: rtl/core/assert_macros.svh
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is applied.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form of the same check.
`define BBA_ASSERT_IMP(lbl, pre, con, msg) \
  `BBA_ASSERT(lbl, (pre) |-> (con), msg)

`endif

FILE: rtl/core/bba_pkg.sv
// Types and constants of the buddy block allocator.
package bba_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 23;
  localparam int unsigned ORD_W  = 4;
  localparam int unsigned CFG_W  = 2;

  localparam logic [CFG_W-1:0] CFG_HEAP_ENABLED = 2'd0;
  localparam logic [CFG_W-1:0] CFG_POOL_ORDER   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_POOL_BASE    = 2'd2;

  localparam logic [7:0] CTL_FREE = 8'h80;
  localparam logic [7:0] CTL_OUT  = 8'h40;

  localparam logic [ORD_W-1:0] RESET_POOL_ORDER = 4'd14;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_DISABLED = 2'd2,
    ST_BADFREE  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef enum logic [4:0] {
    S_CLR, S_INIT, S_IDLE, S_ORDER, S_SEARCH, S_UL1, S_UL2, S_SPLIT,
    S_PU1, S_PU2, S_FCHK, S_FCK, S_MERGE, S_MCHK, S_MHI
  } state_e;

  typedef struct packed {
    logic                command;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   address;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   block_address;
    logic [ORD_W-1:0]    block_order;
    logic [ORD_W-1:0]    merge_count;
  } res_t;

  typedef struct packed {
    logic ctl_re;
    logic ctl_we;
    logic lnk_re;
    logic lnk_we_next;
    logic lnk_we_prev;
  } mem_ctl_t;

endpackage

FILE: rtl/core/bba_mem.sv
// Atom control memory and free list link memory, with registered read data.
module bba_mem #(
  parameter int unsigned AW = 14
) (
  input  logic               clk_i,
  input  bba_pkg::mem_ctl_t  mc_i,
  input  logic [AW-1:0]      ctl_raddr_i,
  input  logic [AW-1:0]      ctl_waddr_i,
  input  logic [7:0]         ctl_wdata_i,
  output logic [7:0]         ctl_rdata_o,
  input  logic [AW-1:0]      lnk_raddr_i,
  input  logic [AW-1:0]      lnk_waddr_i,
  input  logic [AW:0]        lnk_wnext_i,
  input  logic [AW:0]        lnk_wprev_i,
  output logic [AW:0]        lnk_rnext_o,
  output logic [AW:0]        lnk_rprev_o
);

  logic [7:0]  ctl_mem [2**AW];
  logic [AW:0] nxt_mem [2**AW];
  logic [AW:0] prv_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (mc_i.ctl_we) begin
      ctl_mem[ctl_waddr_i] <= ctl_wdata_i;
    end
    if (mc_i.ctl_re) begin
      ctl_rdata_o <= ctl_mem[ctl_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mc_i.lnk_we_next) begin
      nxt_mem[lnk_waddr_i] <= lnk_wnext_i;
    end
    if (mc_i.lnk_we_prev) begin
      prv_mem[lnk_waddr_i] <= lnk_wprev_i;
    end
    if (mc_i.lnk_re) begin
      lnk_rnext_o <= nxt_mem[lnk_raddr_i];
      lnk_rprev_o <= prv_mem[lnk_raddr_i];
    end
  end

endmodule

FILE: rtl/core/bba_ctrl.sv
// Allocation and free sequencer: pool clear, order search, list unlink and push, split and merge.
`include "assert_macros.svh"
module bba_ctrl #(
  parameter int unsigned ATOM_LOG = 8,
  parameter int unsigned AW       = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  bba_pkg::req_t                req_i,
  input  logic                         reinit_i,
  input  logic                         enabled_i,
  input  logic [bba_pkg::ORD_W-1:0]    top_i,
  input  logic [bba_pkg::ADDR_W-1:0]   base_i,
  output logic                         busy_o,
  output logic                         done_o,
  output bba_pkg::res_t                res_o,
  output bba_pkg::mem_ctl_t            mc_o,
  output logic [AW-1:0]                ctl_raddr_o,
  output logic [AW-1:0]                ctl_waddr_o,
  output logic [7:0]                   ctl_wdata_o,
  input  logic [7:0]                   ctl_rdata_i,
  output logic [AW-1:0]                lnk_raddr_o,
  output logic [AW-1:0]                lnk_waddr_o,
  output logic [AW:0]                  lnk_wnext_o,
  output logic [AW:0]                  lnk_wprev_o,
  input  logic [AW:0]                  lnk_rnext_i,
  input  logic [AW:0]                  lnk_rprev_i
);

  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] Nil = {1'b1, {AW{1'b0}}};

  bba_pkg::state_e state_q, state_d;
  logic                         cmd_q, cmd_d;
  logic [bba_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [bba_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [bba_pkg::ORD_W-1:0]    k_q, k_d, lvl_q, lvl_d, merges_q, merges_d;
  logic [bba_pkg::ORD_W:0]      j_q, j_d;
  logic [AW-1:0]                a_q, a_d, tgt_q, tgt_d, clr_q, clr_d;
  logic [LW-1:0]                nx_q, nx_d, pv_q, pv_d, old_q, old_d;
  logic [LW-1:0]                heads_q [16];
  logic                         head_we, heads_init;
  logic [LW-1:0]                head_wdata;
  logic                         done_q, done_d;
  bba_pkg::res_t                res_q, res_d;

  logic [bba_pkg::SIZE_W-1:0]   size_eff;
  logic [bba_pkg::ADDR_W-1:0]   off;
  logic [5:0]                   ctl_ord;
  logic [AW-1:0]                bit_k, bit_j;
  logic [bba_pkg::ORD_W:0]      jn;
  logic [bba_pkg::ADDR_W-1:0]   out_addr;

  assign size_eff = (size_q == '0) ? bba_pkg::SIZE_W'(1) : size_q;
  assign off      = addr_q - base_i;
  assign ctl_ord  = ctl_rdata_i[5:0];
  assign bit_k    = AW'(1) << k_q;
  assign jn       = j_q - 5'd1;
  assign bit_j    = AW'(1) << jn;
  assign out_addr = base_i + (bba_pkg::ADDR_W'(a_q) << ATOM_LOG);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    size_d   = size_q;
    addr_d   = addr_q;
    k_d      = k_q;
    j_d      = j_q;
    lvl_d    = lvl_q;
    merges_d = merges_q;
    a_d      = a_q;
    tgt_d    = tgt_q;
    clr_d    = clr_q;
    nx_d     = nx_q;
    pv_d     = pv_q;
    old_d    = old_q;
    done_d   = 1'b0;
    res_d    = res_q;
    head_we    = 1'b0;
    heads_init = 1'b0;
    head_wdata = Nil;
    mc_o        = '0;
    ctl_raddr_o = a_q;
    ctl_waddr_o = tgt_q;
    ctl_wdata_o = 8'h00;
    lnk_raddr_o = tgt_q;
    lnk_waddr_o = tgt_q;
    lnk_wnext_o = Nil;
    lnk_wprev_o = Nil;

    unique case (state_q)
      bba_pkg::S_CLR: begin
        mc_o.ctl_we = 1'b1;
        ctl_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = bba_pkg::S_INIT;
        end
      end
      bba_pkg::S_INIT: begin
        // The whole pool becomes one free block at atom 0.
        mc_o.ctl_we      = 1'b1;
        mc_o.lnk_we_next = 1'b1;
        mc_o.lnk_we_prev = 1'b1;
        ctl_waddr_o      = '0;
        ctl_wdata_o      = bba_pkg::CTL_FREE | 8'(top_i);
        lnk_waddr_o      = '0;
        heads_init       = 1'b1;
        state_d          = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_d    = req_i.command;
          size_d   = req_i.request_size;
          addr_d   = req_i.address;
          merges_d = '0;
          res_d    = '0;
          if (!enabled_i) begin
            done_d       = 1'b1;
            res_d.status = bba_pkg::ST_DISABLED;
          end else if (req_i.command == bba_pkg::CMD_FREE) begin
            state_d = bba_pkg::S_FCHK;
          end else if ({9'd0, req_i.request_size} >
                       (32'd1 << (5'(top_i) + 5'(ATOM_LOG)))) begin
            done_d       = 1'b1;
            res_d.status = bba_pkg::ST_OOM;
          end else begin
            k_d     = '0;
            state_d = bba_pkg::S_ORDER;
          end
        end
      end
      bba_pkg::S_ORDER: begin
        if (k_q < top_i && ((32'd1 << (5'(k_q) + 5'(ATOM_LOG))) < {9'd0, size_eff})) begin
          k_d = k_q + 4'd1;
        end else begin
          j_d     = {1'b0, k_q};
          state_d = bba_pkg::S_SEARCH;
        end
      end
      bba_pkg::S_SEARCH: begin
        if (j_q > {1'b0, top_i}) begin
          done_d       = 1'b1;
          res_d.status = bba_pkg::ST_OOM;
          state_d      = bba_pkg::S_IDLE;
        end else if (heads_q[j_q[3:0]] == Nil) begin
          j_d = j_q + 5'd1;
        end else begin
          a_d         = heads_q[j_q[3:0]][AW-1:0];
          tgt_d       = heads_q[j_q[3:0]][AW-1:0];
          lvl_d       = j_q[3:0];
          mc_o.lnk_re = 1'b1;
          lnk_raddr_o = heads_q[j_q[3:0]][AW-1:0];
          state_d     = bba_pkg::S_UL1;
        end
      end
      bba_pkg::S_UL1: begin
        nx_d        = lnk_rnext_i;
        pv_d        = lnk_rprev_i;
        mc_o.ctl_we = 1'b1;
        ctl_waddr_o = tgt_q;
        if (lnk_rprev_i != Nil) begin
          mc_o.lnk_we_next = 1'b1;
          lnk_waddr_o      = lnk_rprev_i[AW-1:0];
          lnk_wnext_o      = lnk_rnext_i;
        end else begin
          head_we    = 1'b1;
          head_wdata = lnk_rnext_i;
        end
        state_d = bba_pkg::S_UL2;
      end
      bba_pkg::S_UL2: begin
        if (nx_q != Nil) begin
          mc_o.lnk_we_prev = 1'b1;
          lnk_waddr_o      = nx_q[AW-1:0];
          lnk_wprev_o      = pv_q;
        end
        state_d = (cmd_q == bba_pkg::CMD_ALLOC) ? bba_pkg::S_SPLIT : bba_pkg::S_MHI;
      end
      bba_pkg::S_SPLIT: begin
        if (j_q > {1'b0, k_q}) begin
          // Upper half of the current block goes onto the next lower list.
          j_d     = jn;
          tgt_d   = a_q + bit_j;
          lvl_d   = jn[3:0];
          state_d = bba_pkg::S_PU1;
        end else begin
          mc_o.ctl_we             = 1'b1;
          ctl_waddr_o             = a_q;
          ctl_wdata_o             = bba_pkg::CTL_OUT | 8'(k_q);
          done_d                  = 1'b1;
          res_d.status            = bba_pkg::ST_OK;
          res_d.block_address     = out_addr;
          res_d.block_order       = k_q;
          res_d.merge_count       = '0;
          state_d                 = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_PU1: begin
        mc_o.ctl_we      = 1'b1;
        ctl_waddr_o      = tgt_q;
        ctl_wdata_o      = bba_pkg::CTL_FREE | 8'(lvl_q);
        mc_o.lnk_we_next = 1'b1;
        mc_o.lnk_we_prev = 1'b1;
        lnk_waddr_o      = tgt_q;
        lnk_wnext_o      = heads_q[lvl_q];
        lnk_wprev_o      = Nil;
        old_d            = heads_q[lvl_q];
        head_we          = 1'b1;
        head_wdata       = {1'b0, tgt_q};
        state_d          = bba_pkg::S_PU2;
      end
      bba_pkg::S_PU2: begin
        if (old_q != Nil) begin
          mc_o.lnk_we_prev = 1'b1;
          lnk_waddr_o      = old_q[AW-1:0];
          lnk_wprev_o      = {1'b0, tgt_q};
        end
        if (cmd_q == bba_pkg::CMD_ALLOC) begin
          state_d = bba_pkg::S_SPLIT;
        end else begin
          done_d              = 1'b1;
          res_d.status        = bba_pkg::ST_OK;
          res_d.block_address = out_addr;
          res_d.block_order   = k_q;
          res_d.merge_count   = merges_q;
          state_d             = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_FCHK: begin
        if (addr_q < base_i || (off >> (6'(top_i) + 6'(ATOM_LOG))) != '0 ||
            off[ATOM_LOG-1:0] != '0) begin
          done_d       = 1'b1;
          res_d.status = bba_pkg::ST_BADFREE;
          state_d      = bba_pkg::S_IDLE;
        end else begin
          a_d         = off[ATOM_LOG +: AW];
          mc_o.ctl_re = 1'b1;
          ctl_raddr_o = off[ATOM_LOG +: AW];
          state_d     = bba_pkg::S_FCK;
        end
      end
      bba_pkg::S_FCK: begin
        if ((ctl_rdata_i & bba_pkg::CTL_OUT) == 8'h00) begin
          done_d       = 1'b1;
          res_d.status = bba_pkg::ST_BADFREE;
          state_d      = bba_pkg::S_IDLE;
        end else begin
          k_d     = (ctl_ord > 6'(top_i)) ? top_i : ctl_ord[3:0];
          state_d = bba_pkg::S_MERGE;
        end
      end
      bba_pkg::S_MERGE: begin
        if (k_q < top_i) begin
          tgt_d       = a_q ^ bit_k;
          mc_o.ctl_re = 1'b1;
          ctl_raddr_o = a_q ^ bit_k;
          state_d     = bba_pkg::S_MCHK;
        end else begin
          tgt_d   = a_q;
          lvl_d   = k_q;
          state_d = bba_pkg::S_PU1;
        end
      end
      bba_pkg::S_MCHK: begin
        if (ctl_rdata_i != (bba_pkg::CTL_FREE | 8'(k_q))) begin
          tgt_d   = a_q;
          lvl_d   = k_q;
          state_d = bba_pkg::S_PU1;
        end else begin
          lvl_d       = k_q;
          mc_o.lnk_re = 1'b1;
          lnk_raddr_o = tgt_q;
          state_d     = bba_pkg::S_UL1;
        end
      end
      bba_pkg::S_MHI: begin
        // The upper half loses its block marker; the pair continues as the lower half.
        mc_o.ctl_we = 1'b1;
        ctl_waddr_o = a_q | bit_k;
        a_d         = a_q & ~bit_k;
        k_d         = k_q + 4'd1;
        merges_d    = merges_q + 4'd1;
        state_d     = bba_pkg::S_MERGE;
      end
      default: begin
        state_d = bba_pkg::S_CLR;
      end
    endcase

    if (reinit_i) begin
      state_d = bba_pkg::S_CLR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        heads_q[i] <= Nil;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (heads_init) begin
        for (int i = 0; i < 16; i++) begin
          heads_q[i] <= (4'(i) == top_i) ? '0 : Nil;
        end
      end else if (head_we) begin
        heads_q[lvl_q] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    size_q   <= size_d;
    addr_q   <= addr_d;
    k_q      <= k_d;
    j_q      <= j_d;
    lvl_q    <= lvl_d;
    merges_q <= merges_d;
    a_q      <= a_d;
    tgt_q    <= tgt_d;
    nx_q     <= nx_d;
    pv_q     <= pv_d;
    old_q    <= old_d;
    res_q    <= res_d;
  end

  assign busy_o = (state_q != bba_pkg::S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `BBA_ASSERT_IMP(a_done_idle, done_q, state_q == bba_pkg::S_IDLE,
                  "result strobe outside the idle state")
  `BBA_ASSERT_IMP(a_split_order, state_q == bba_pkg::S_SPLIT, j_q >= {1'b0, k_q},
                  "split level fell below the requested order")
  `BBA_ASSERT_IMP(a_merge_bound, cmd_q == bba_pkg::CMD_FREE && state_q == bba_pkg::S_MERGE,
                  merges_q <= top_i && k_q <= top_i, "merge ran past the pool order")

endmodule

FILE: rtl/core/buddy_block_allocator.sv
// Buddy block allocator top level: configuration registers, sequencer and memories.
// Allocate of order k from a list at order j: order search, list search, unlink, then one
// split per level down to k; the answer comes straight from idle when the heap is off or
// the size exceeds the pool. Free: address check, control read, buddy merges up to the
// pool order, then a push; a bad free answers after either check. One request is worked
// at a time. After reset and each pool_order write, with busy high, the block clears
// 2^(HEAP_LOG-ATOM_LOG) control entries, one per cycle, then writes one free block.
module buddy_block_allocator #(
  parameter int unsigned ATOM_LOG = 8,
  parameter int unsigned HEAP_LOG = 22
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bba_pkg::req_t                req_i,
  output logic                         done_o,
  output bba_pkg::res_t                res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bba_pkg::CFG_W-1:0]    cfg_index_i,
  input  logic [bba_pkg::ADDR_W-1:0]   cfg_data_i
);

  localparam int unsigned MaxOrder = HEAP_LOG - ATOM_LOG;
  localparam int unsigned AW       = (MaxOrder > 0) ? MaxOrder : 1;

  logic                         enabled_q;
  logic [bba_pkg::ORD_W-1:0]    porder_q, top;
  logic [bba_pkg::ADDR_W-1:0]   base_q;
  logic                         cfg_we, reinit;

  bba_pkg::mem_ctl_t mc;
  logic [AW-1:0] ctl_raddr, ctl_waddr, lnk_raddr, lnk_waddr;
  logic [7:0]    ctl_wdata, ctl_rdata;
  logic [AW:0]   lnk_wnext, lnk_wprev, lnk_rnext, lnk_rprev;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign reinit      = cfg_we && (cfg_index_i == bba_pkg::CFG_POOL_ORDER);
  assign top = (int'(porder_q) > MaxOrder) ? bba_pkg::ORD_W'(MaxOrder) : porder_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      porder_q  <= bba_pkg::RESET_POOL_ORDER;
      base_q    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        bba_pkg::CFG_HEAP_ENABLED: enabled_q <= cfg_data_i[0];
        bba_pkg::CFG_POOL_ORDER:   porder_q  <= cfg_data_i[bba_pkg::ORD_W-1:0];
        bba_pkg::CFG_POOL_BASE:    base_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bba_ctrl #(
    .ATOM_LOG(ATOM_LOG),
    .AW      (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start && !busy),
    .req_i       (req_i),
    .reinit_i    (reinit),
    .enabled_i   (enabled_q),
    .top_i       (top),
    .base_i      (base_q),
    .busy_o      (busy),
    .done_o      (done_o),
    .res_o       (res_o),
    .mc_o        (mc),
    .ctl_raddr_o (ctl_raddr),
    .ctl_waddr_o (ctl_waddr),
    .ctl_wdata_o (ctl_wdata),
    .ctl_rdata_i (ctl_rdata),
    .lnk_raddr_o (lnk_raddr),
    .lnk_waddr_o (lnk_waddr),
    .lnk_wnext_o (lnk_wnext),
    .lnk_wprev_o (lnk_wprev),
    .lnk_rnext_i (lnk_rnext),
    .lnk_rprev_i (lnk_rprev)
  );

  bba_mem #(
    .AW(AW)
  ) u_mem (
    .clk_i       (clk_i),
    .mc_i        (mc),
    .ctl_raddr_i (ctl_raddr),
    .ctl_waddr_i (ctl_waddr),
    .ctl_wdata_i (ctl_wdata),
    .ctl_rdata_o (ctl_rdata),
    .lnk_raddr_i (lnk_raddr),
    .lnk_waddr_i (lnk_waddr),
    .lnk_wnext_i (lnk_wnext),
    .lnk_wprev_i (lnk_wprev),
    .lnk_rnext_o (lnk_rnext),
    .lnk_rprev_o (lnk_rprev)
  );

endmodule
